@@ src/gws_pkg.sv @@
// Shared constants, types and helper functions of the grid word search block.
`timescale 1ns / 1ps

package gws_pkg;

  // Grid store size (32 rows by 32 columns)
  localparam int MAX_ROWS    = 32;
  localparam int MAX_COLS    = 32;
  localparam int ROW_W       = $clog2(MAX_ROWS);
  localparam int COL_W       = $clog2(MAX_COLS);
  localparam int GRID_DEPTH  = MAX_ROWS * MAX_COLS;
  localparam int GRID_AW     = $clog2(GRID_DEPTH);

  // Search area cap and register width
  localparam int FIELD_LIMIT = 32;
  localparam int SPAN_W      = 6;
  localparam int ROW_CAP     = (MAX_ROWS < FIELD_LIMIT) ? MAX_ROWS : FIELD_LIMIT;
  localparam int COL_CAP     = (MAX_COLS < FIELD_LIMIT) ? MAX_COLS : FIELD_LIMIT;

  // Word store
  localparam int CHAR_W      = 8;
  localparam int WORD_DEPTH  = 32;
  localparam int WORD_AW     = $clog2(WORD_DEPTH);
  localparam int LEN_W       = WORD_AW + 1;

  // Output field widths
  localparam int MATCH_W     = 5;

  // Reset value of the span registers
  localparam logic [SPAN_W-1:0] SPAN_RESET = SPAN_W'(20);

  // Configuration register indexes
  localparam logic CFG_ROWS = 1'b0;
  localparam logic CFG_COLS = 1'b1;

  // Request codes
  localparam logic CMD_GRID = 1'b0;
  localparam logic CMD_WORD = 1'b1;

  // Step codes of one direction axis
  localparam logic [1:0] STEP_ZERO = 2'b00;
  localparam logic [1:0] STEP_POS  = 2'b01;
  localparam logic [1:0] STEP_NEG  = 2'b11;

  localparam int DIR_W = 3;
  localparam logic [DIR_W-1:0] DIR_LAST = 3'd7;

  // Search start request
  typedef struct packed {
    logic              start;
    logic [LEN_W-1:0]  len;
    logic              overflow;
  } search_req_t;

  // Search result
  typedef struct packed {
    logic               valid;
    logic               found;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic               too_long;
  } search_res_t;

  // Row step of direction d: row outer, column inner, center skipped
  function automatic logic [1:0] dir_row_step(input logic [DIR_W-1:0] d);
    logic [1:0] s;
    case (d)
      3'd0, 3'd1, 3'd2: s = STEP_NEG;
      3'd3, 3'd4:       s = STEP_ZERO;
      default:          s = STEP_POS;
    endcase
    return s;
  endfunction

  // Column step of direction d
  function automatic logic [1:0] dir_col_step(input logic [DIR_W-1:0] d);
    logic [1:0] s;
    case (d)
      3'd0, 3'd3, 3'd5: s = STEP_NEG;
      3'd1, 3'd6:       s = STEP_ZERO;
      default:          s = STEP_POS;
    endcase
    return s;
  endfunction

  // Linear grid address of a cell
  function automatic logic [GRID_AW-1:0] grid_addr(input logic [ROW_W-1:0] r,
                                                    input logic [COL_W-1:0] c);
    return GRID_AW'(r) * GRID_AW'(MAX_COLS) + GRID_AW'(c);
  endfunction

endpackage

@@ src/grid_word_search_8dir.sv @@
// Top level of the eight-direction grid word search block.
`timescale 1ns / 1ps

// A request with cmd 0 writes one grid cell; a request with cmd 1 appends a
// word character. Both are taken only while in_ready is high. A cmd 1 request
// that carries word_end starts a search, and in_ready stays low until its
// result has been moved into the output register. The search is sequenced
// over one shared bounds-and-compare unit against the grid RAM: for each start
// cell and direction the end cell is bounds-tested first, and each compared
// character takes a registered RAM read, then a compare. The result is then
// handed over, held while the output register is still full. A word that
// overflowed the 32-character store, or an empty area in use, skips the walk,
// so in_ready is low only while the result is handed over; an overflowed word
// reports too_long. No reset clearing pass is needed.
module grid_word_search_8dir (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic                               in_cmd,
  input  logic [gws_pkg::ROW_W-1:0]          in_cell_row,
  input  logic [gws_pkg::COL_W-1:0]          in_cell_col,
  input  logic [gws_pkg::CHAR_W-1:0]         in_char_code,
  input  logic                               in_word_end,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic                               out_found,
  output logic [gws_pkg::MATCH_W-1:0]        out_match_row,
  output logic [gws_pkg::MATCH_W-1:0]        out_match_col,
  output logic                               out_too_long,
  input  logic                               cfg_we,
  input  logic                               cfg_index,
  input  logic [gws_pkg::SPAN_W-1:0]         cfg_data
);

  logic [gws_pkg::SPAN_W-1:0]   rows_r, cols_r;
  logic [gws_pkg::LEN_W-1:0]    wlen_r, wlen_nxt;
  logic                         wovf_r, wovf_nxt;
  logic                         out_valid_r;
  logic                         found_r, too_long_r;
  logic [gws_pkg::MATCH_W-1:0]  mrow_r, mcol_r;

  logic                         accept, grid_we, word_we, out_free, busy;
  logic [gws_pkg::LEN_W-1:0]    len_new;
  logic                         ovf_new;
  gws_pkg::search_req_t         req;
  gws_pkg::search_res_t         res;
  logic [gws_pkg::GRID_AW-1:0]  grid_raddr;
  logic [gws_pkg::CHAR_W-1:0]   grid_rdata, word_rdata;
  logic [gws_pkg::WORD_AW-1:0]  word_raddr;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= gws_pkg::SPAN_RESET;
      cols_r <= gws_pkg::SPAN_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        gws_pkg::CFG_ROWS: rows_r <= cfg_data;
        gws_pkg::CFG_COLS: cols_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign in_ready = !busy;
  assign accept   = in_valid && in_ready;
  assign grid_we  = accept && (in_cmd == gws_pkg::CMD_GRID) &&
                    ({1'b0, in_cell_row} < (gws_pkg::ROW_W+1)'(gws_pkg::MAX_ROWS)) &&
                    ({1'b0, in_cell_col} < (gws_pkg::COL_W+1)'(gws_pkg::MAX_COLS));
  assign word_we  = accept && (in_cmd == gws_pkg::CMD_WORD) &&
                    (wlen_r < gws_pkg::LEN_W'(gws_pkg::WORD_DEPTH));

  // Append a word character or flag overflow; clear on word end
  always_comb begin
    len_new  = word_we ? wlen_r + gws_pkg::LEN_W'(1) : wlen_r;
    ovf_new  = wovf_r || (accept && (in_cmd == gws_pkg::CMD_WORD) && !word_we);
    wlen_nxt = wlen_r;
    wovf_nxt = wovf_r;
    req      = '0;
    if (accept && in_cmd == gws_pkg::CMD_WORD) begin
      if (in_word_end) begin
        req.start    = 1'b1;
        req.len      = len_new;
        req.overflow = ovf_new;
        wlen_nxt     = '0;
        wovf_nxt     = 1'b0;
      end else begin
        wlen_nxt = len_new;
        wovf_nxt = ovf_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wlen_r <= '0;
      wovf_r <= 1'b0;
    end else begin
      wlen_r <= wlen_nxt;
      wovf_r <= wovf_nxt;
    end
  end

  gws_ram #(
    .WIDTH(gws_pkg::CHAR_W),
    .DEPTH(gws_pkg::GRID_DEPTH)
  ) u_grid_ram (
    .clk  (clk),
    .we   (grid_we),
    .waddr(gws_pkg::grid_addr(in_cell_row, in_cell_col)),
    .wdata(in_char_code),
    .raddr(grid_raddr),
    .rdata(grid_rdata)
  );

  gws_ram #(
    .WIDTH(gws_pkg::CHAR_W),
    .DEPTH(gws_pkg::WORD_DEPTH)
  ) u_word_ram (
    .clk  (clk),
    .we   (word_we),
    .waddr(wlen_r[gws_pkg::WORD_AW-1:0]),
    .wdata(in_char_code),
    .raddr(word_raddr),
    .rdata(word_rdata)
  );

  gws_search u_search (
    .clk        (clk),
    .rst_n      (rst_n),
    .req        (req),
    .rows_in_use(rows_r),
    .cols_in_use(cols_r),
    .out_free   (out_free),
    .busy       (busy),
    .res        (res),
    .grid_raddr (grid_raddr),
    .grid_rdata (grid_rdata),
    .word_raddr (word_raddr),
    .word_rdata (word_rdata)
  );

  // Output register: load a finished result, drop it when taken
  assign out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res.valid) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      found_r    <= res.found;
      mrow_r     <= gws_pkg::MATCH_W'(res.row);
      mcol_r     <= gws_pkg::MATCH_W'(res.col);
      too_long_r <= res.too_long;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_found     = found_r;
  assign out_match_row = mrow_r;
  assign out_match_col = mcol_r;
  assign out_too_long  = too_long_r;

endmodule

@@ src/gws_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module gws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

@@ src/gws_search.sv @@
// Search sequencer: walks start cells and directions, compares one character at a time.
`timescale 1ns / 1ps

module gws_search (
  input  logic                               clk,
  input  logic                               rst_n,
  input  gws_pkg::search_req_t               req,
  input  logic [gws_pkg::SPAN_W-1:0]         rows_in_use,
  input  logic [gws_pkg::SPAN_W-1:0]         cols_in_use,
  input  logic                               out_free,
  output logic                               busy,
  output gws_pkg::search_res_t               res,
  output logic [gws_pkg::GRID_AW-1:0]        grid_raddr,
  input  logic [gws_pkg::CHAR_W-1:0]         grid_rdata,
  output logic [gws_pkg::WORD_AW-1:0]        word_raddr,
  input  logic [gws_pkg::CHAR_W-1:0]         word_rdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_BOUND = 3'd1;
  localparam logic [2:0] S_RD    = 3'd2;
  localparam logic [2:0] S_CMP   = 3'd3;
  localparam logic [2:0] S_DONE  = 3'd4;

  logic [2:0]                        state_r, state_nxt;
  logic [gws_pkg::ROW_W-1:0]         r_r, r_nxt, pr_r, pr_nxt;
  logic [gws_pkg::COL_W-1:0]         c_r, c_nxt, pc_r, pc_nxt;
  logic [gws_pkg::DIR_W-1:0]         d_r, d_nxt;
  logic [gws_pkg::WORD_AW-1:0]       i_r, i_nxt;
  logic [gws_pkg::LEN_W-1:0]         len_r, len_nxt;
  logic                              found_r, found_nxt;
  logic                              ovf_r, ovf_nxt;

  logic [gws_pkg::SPAN_W-1:0]        rows_lim, cols_lim;
  logic [1:0]                        dr, dc;
  logic [gws_pkg::LEN_W-1:0]         span;
  logic                              row_ok, col_ok;
  logic                              last_dir, last_col, last_row;
  logic [gws_pkg::ROW_W-1:0]         dr_ext;
  logic [gws_pkg::COL_W-1:0]         dc_ext;

  // Clamp the search area to the store
  always_comb begin
    rows_lim = (rows_in_use > gws_pkg::SPAN_W'(gws_pkg::ROW_CAP)) ?
               gws_pkg::SPAN_W'(gws_pkg::ROW_CAP) : rows_in_use;
    cols_lim = (cols_in_use > gws_pkg::SPAN_W'(gws_pkg::COL_CAP)) ?
               gws_pkg::SPAN_W'(gws_pkg::COL_CAP) : cols_in_use;
  end

  // Direction steps and the end-cell bounds test
  always_comb begin
    dr     = gws_pkg::dir_row_step(d_r);
    dc     = gws_pkg::dir_col_step(d_r);
    dr_ext = {{(gws_pkg::ROW_W-1){dr[1]}}, dr[0]};
    dc_ext = {{(gws_pkg::COL_W-1){dc[1]}}, dc[0]};
    span   = len_r - gws_pkg::LEN_W'(1);
    case (dr)
      gws_pkg::STEP_NEG: row_ok = (gws_pkg::LEN_W'(r_r) >= span);
      gws_pkg::STEP_POS: row_ok = ((7'(r_r) + 7'(span)) < 7'(rows_lim));
      default:           row_ok = 1'b1;
    endcase
    case (dc)
      gws_pkg::STEP_NEG: col_ok = (gws_pkg::LEN_W'(c_r) >= span);
      gws_pkg::STEP_POS: col_ok = ((7'(c_r) + 7'(span)) < 7'(cols_lim));
      default:           col_ok = 1'b1;
    endcase
    last_dir = (d_r == gws_pkg::DIR_LAST);
    last_col = (gws_pkg::SPAN_W'(c_r) == cols_lim - gws_pkg::SPAN_W'(1));
    last_row = (gws_pkg::SPAN_W'(r_r) == rows_lim - gws_pkg::SPAN_W'(1));
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    r_nxt     = r_r;
    c_nxt     = c_r;
    d_nxt     = d_r;
    i_nxt     = i_r;
    pr_nxt    = pr_r;
    pc_nxt    = pc_r;
    len_nxt   = len_r;
    found_nxt = found_r;
    ovf_nxt   = ovf_r;
    unique case (state_r)
      S_IDLE: begin
        if (req.start) begin
          len_nxt   = req.len;
          ovf_nxt   = req.overflow;
          found_nxt = 1'b0;
          r_nxt     = '0;
          c_nxt     = '0;
          d_nxt     = '0;
          if (req.overflow || rows_lim == '0 || cols_lim == '0) begin
            state_nxt = S_DONE;
          end else begin
            state_nxt = S_BOUND;
          end
        end
      end
      S_BOUND: begin
        if (row_ok && col_ok) begin
          pr_nxt    = r_r;
          pc_nxt    = c_r;
          i_nxt     = '0;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CMP;
      end
      S_CMP: begin
        if (grid_rdata == word_rdata) begin
          if (gws_pkg::LEN_W'(i_r) == span) begin
            found_nxt = 1'b1;
            state_nxt = S_DONE;
          end else begin
            i_nxt     = i_r + gws_pkg::WORD_AW'(1);
            pr_nxt    = pr_r + dr_ext;
            pc_nxt    = pc_r + dc_ext;
            state_nxt = S_RD;
          end
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // Advance to the next direction or start cell on a rejected try
    if ((state_r == S_BOUND && !(row_ok && col_ok)) ||
        (state_r == S_CMP && grid_rdata != word_rdata)) begin
      state_nxt = S_BOUND;
      if (!last_dir) begin
        d_nxt = d_r + gws_pkg::DIR_W'(1);
      end else begin
        d_nxt = '0;
        if (!last_col) begin
          c_nxt = c_r + gws_pkg::COL_W'(1);
        end else begin
          c_nxt = '0;
          if (last_row) begin
            state_nxt = S_DONE;
          end else begin
            r_nxt = r_r + gws_pkg::ROW_W'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    r_r     <= r_nxt;
    c_r     <= c_nxt;
    d_r     <= d_nxt;
    i_r     <= i_nxt;
    pr_r    <= pr_nxt;
    pc_r    <= pc_nxt;
    len_r   <= len_nxt;
    found_r <= found_nxt;
    ovf_r   <= ovf_nxt;
  end

  // Memory read addresses for the current character
  assign grid_raddr = gws_pkg::grid_addr(pr_r, pc_r);
  assign word_raddr = i_r;

  // Hand the result over once the output slot is free
  assign busy         = (state_r != S_IDLE);
  assign res.valid    = (state_r == S_DONE) && out_free;
  assign res.found    = found_r;
  assign res.row      = found_r ? r_r : '0;
  assign res.col      = found_r ? c_r : '0;
  assign res.too_long = ovf_r;

endmodule

@@ test/tb_grid_word_search_8dir.sv @@
// Testbench of the grid word search block: random grid and word requests against a shadow search.
`timescale 1ns / 1ps

module tb_grid_word_search_8dir;
  import gws_pkg::*;

  localparam int STALL_LIMIT   = 200000;
  localparam int SETTLE_CYCLES = 20;
  localparam int ITEM_TARGET   = 740;
  localparam int CALM_FROM     = 620;
  localparam int MIN_WORDS     = 40;

  typedef struct {
    logic              cmd;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [CHAR_W-1:0] ch;
    logic              last;
  } request_t;

  typedef struct {
    logic               found;
    logic [MATCH_W-1:0] row;
    logic [MATCH_W-1:0] col;
    logic               too_long;
  } match_t;

  logic                clk           = 1'b0;
  logic                rst_n         = 1'b0;
  logic                in_valid      = 1'b0;
  logic                in_cmd        = CMD_GRID;
  logic [ROW_W-1:0]    in_cell_row   = '0;
  logic [COL_W-1:0]    in_cell_col   = '0;
  logic [CHAR_W-1:0]   in_char_code  = '0;
  logic                in_word_end   = 1'b0;
  logic                out_ready     = 1'b0;
  logic                cfg_we        = 1'b0;
  logic                cfg_index     = CFG_ROWS;
  logic [SPAN_W-1:0]   cfg_data      = '0;
  logic                in_ready;
  logic                out_valid;
  logic                out_found;
  logic [MATCH_W-1:0]  out_match_row;
  logic [MATCH_W-1:0]  out_match_col;
  logic                out_too_long;

  // Shadow state of the search block
  logic [CHAR_W-1:0]   grid_mem [GRID_DEPTH];
  logic [CHAR_W-1:0]   word_mem [WORD_DEPTH];
  int                  word_len = 0;
  bit                  word_ovf = 1'b0;
  logic [SPAN_W-1:0]   rows_cfg = SPAN_RESET;
  logic [SPAN_W-1:0]   cols_cfg = SPAN_RESET;

  // Stimulus planning view of the grid
  logic [CHAR_W-1:0]   plan_grid [GRID_DEPTH];
  bit                  plan_written [GRID_DEPTH];
  logic [CHAR_W-1:0]   plan_word [$];
  int                  plan_rows = 0;
  int                  plan_cols = 0;

  request_t            request_q [$];
  match_t              pending_matches [$];
  int                  n_queued   = 0;
  int                  n_accepted = 0;
  int                  n_words    = 0;
  int                  n_mismatch = 0;
  bit                  calm       = 1'b0;

  grid_word_search_8dir i_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_cmd        (in_cmd),
    .in_cell_row   (in_cell_row),
    .in_cell_col   (in_cell_col),
    .in_char_code  (in_char_code),
    .in_word_end   (in_word_end),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_found     (out_found),
    .out_match_row (out_match_row),
    .out_match_col (out_match_col),
    .out_too_long  (out_too_long),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // First start cell and direction at which the stored word lies in the area in use
  function automatic bit locate_word(output int hit_r, output int hit_c);
    int rows, cols, r, c, dr, dc, er, ec, k, rr, cc;
    bit ok;
    hit_r = 0;
    hit_c = 0;
    rows = (rows_cfg < ROW_CAP) ? int'(rows_cfg) : ROW_CAP;
    cols = (cols_cfg < COL_CAP) ? int'(cols_cfg) : COL_CAP;
    for (r = 0; r < rows; r++) begin
      for (c = 0; c < cols; c++) begin
        for (dr = -1; dr <= 1; dr++) begin
          for (dc = -1; dc <= 1; dc++) begin
            if (dr == 0 && dc == 0) continue;
            er = r + (word_len - 1) * dr;
            ec = c + (word_len - 1) * dc;
            if (er < 0 || er >= rows || ec < 0 || ec >= cols) continue;
            ok = 1'b1;
            rr = r;
            cc = c;
            for (k = 0; k < word_len && ok; k++) begin
              if (grid_mem[rr * MAX_COLS + cc] != word_mem[k]) ok = 1'b0;
              rr += dr;
              cc += dc;
            end
            if (ok) begin
              hit_r = r;
              hit_c = c;
              return 1'b1;
            end
          end
        end
      end
    end
    return 1'b0;
  endfunction

  // Apply one accepted request to the shadow state; queue the match it yields
  task automatic track_request(input request_t rq);
    match_t m;
    int hr, hc;
    bit hit;
    if (rq.cmd == CMD_GRID) begin
      if (int'(rq.row) < MAX_ROWS && int'(rq.col) < MAX_COLS)
        grid_mem[int'(rq.row) * MAX_COLS + int'(rq.col)] = rq.ch;
      return;
    end
    if (word_len < WORD_DEPTH) begin
      word_mem[word_len] = rq.ch;
      word_len++;
    end else begin
      word_ovf = 1'b1;
    end
    if (!rq.last) return;
    hit = 1'b0;
    hr = 0;
    hc = 0;
    if (!word_ovf) hit = locate_word(hr, hc);
    m.found    = hit;
    m.row      = hit ? MATCH_W'(hr) : '0;
    m.col      = hit ? MATCH_W'(hc) : '0;
    m.too_long = word_ovf;
    pending_matches.push_back(m);
    word_len = 0;
    word_ovf = 1'b0;
  endtask

  // Request driver: hold each request until taken, insert random gaps
  request_t cur_req;
  int       gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        track_request(cur_req);
        n_accepted++;
      end
      if (!in_valid || in_ready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (request_q.size() > 0 && !calm && $urandom_range(0, 9) == 0) begin
          gap_left = $urandom_range(0, 10);
          in_valid <= 1'b0;
        end else if (request_q.size() > 0) begin
          cur_req = request_q.pop_front();
          in_cmd       <= cur_req.cmd;
          in_cell_row  <= cur_req.row;
          in_cell_col  <= cur_req.col;
          in_char_code <= cur_req.ch;
          in_word_end  <= cur_req.last;
          in_valid     <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each taken result with the oldest expected match
  match_t got;
  match_t want;
  int     stall_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got.found    = out_found;
        got.row      = out_match_row;
        got.col      = out_match_col;
        got.too_long = out_too_long;
        if (pending_matches.size() == 0) begin
          if (n_mismatch < 10)
            $display("unexpected result: found %0d row %0d col %0d too_long %0d",
                     got.found, got.row, got.col, got.too_long);
          n_mismatch++;
        end else begin
          want = pending_matches.pop_front();
          if (got.found !== want.found || got.row !== want.row ||
              got.col !== want.col || got.too_long !== want.too_long) begin
            if (n_mismatch < 10)
              $display("mismatch: expected found %0d row %0d col %0d too_long %0d, %s",
                       want.found, want.row, want.col, want.too_long,
                       $sformatf("got found %0d row %0d col %0d too_long %0d",
                                 got.found, got.row, got.col, got.too_long));
            n_mismatch++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 10);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  int stuck_cycles = 0;

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // Wait until every request is taken and every match has come back
  task automatic settle();
    while (n_accepted != n_queued || pending_matches.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write both span registers while the block is idle
  task automatic set_area(input logic [SPAN_W-1:0] r, input logic [SPAN_W-1:0] c);
    settle();
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_ROWS;
    cfg_data  <= r;
    @(posedge clk);
    cfg_index <= CFG_COLS;
    cfg_data  <= c;
    @(posedge clk);
    cfg_we    <= 1'b0;
    rows_cfg  = r;
    cols_cfg  = c;
    plan_rows = (r < ROW_CAP) ? int'(r) : ROW_CAP;
    plan_cols = (c < COL_CAP) ? int'(c) : COL_CAP;
  endtask

  task automatic push_cell(input int r, input int c, input logic [CHAR_W-1:0] ch);
    request_t rq;
    rq.cmd  = CMD_GRID;
    rq.row  = ROW_W'(r);
    rq.col  = COL_W'(c);
    rq.ch   = ch;
    rq.last = 1'($urandom_range(0, 1));
    request_q.push_back(rq);
    n_queued++;
    plan_grid[r * MAX_COLS + c]    = ch;
    plan_written[r * MAX_COLS + c] = 1'b1;
  endtask

  // Send the planned word, one character per request, the last one marked
  task automatic push_word();
    request_t rq;
    foreach (plan_word[i]) begin
      rq.cmd  = CMD_WORD;
      rq.row  = ROW_W'($urandom_range(0, MAX_ROWS - 1));
      rq.col  = COL_W'($urandom_range(0, MAX_COLS - 1));
      rq.ch   = plan_word[i];
      rq.last = (i == plan_word.size() - 1);
      request_q.push_back(rq);
      n_queued++;
    end
    n_words++;
  endtask

  // Mostly a small alphabet so that partial matches are common
  function automatic logic [CHAR_W-1:0] pick_char();
    if ($urandom_range(0, 7) == 0) return CHAR_W'($urandom_range(0, 255));
    return CHAR_W'(8'h41 + $urandom_range(0, 3));
  endfunction

  task automatic plan_random_word(input int n);
    plan_word.delete();
    repeat (n) plan_word.push_back(pick_char());
  endtask

  // Read a word off the planned grid along a random line, sometimes spoil its tail
  task automatic plan_path_word();
    int r, c, dr, dc, reach, n, k;
    if (plan_rows == 0 || plan_cols == 0) begin
      plan_random_word($urandom_range(1, 6));
      return;
    end
    r = $urandom_range(0, plan_rows - 1);
    c = $urandom_range(0, plan_cols - 1);
    do begin
      dr = int'($urandom_range(0, 2)) - 1;
      dc = int'($urandom_range(0, 2)) - 1;
    end while (dr == 0 && dc == 0);
    reach = 1;
    while (reach < WORD_DEPTH && r + reach * dr >= 0 && r + reach * dr < plan_rows &&
           c + reach * dc >= 0 && c + reach * dc < plan_cols)
      reach++;
    n = $urandom_range(1, (reach < 8) ? reach : 8);
    plan_word.delete();
    for (k = 0; k < n; k++)
      plan_word.push_back(plan_grid[(r + k * dr) * MAX_COLS + c + k * dc]);
    if ($urandom_range(0, 4) == 0) plan_word[n - 1] = plan_word[n - 1] ^ 8'h01;
  endtask

  // Write every cell of the area in use that has no value yet
  task automatic fill_area();
    for (int r = 0; r < plan_rows; r++)
      for (int c = 0; c < plan_cols; c++)
        if (!plan_written[r * MAX_COLS + c]) push_cell(r, c, pick_char());
  endtask

  initial begin
    int phase, sel, n_body, kind;
    logic [SPAN_W-1:0] r_sel, c_sel;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: small area, byte extremes, every request kind
    set_area(SPAN_W'(2), SPAN_W'(3));
    push_cell(0, 0, 8'h00);
    push_cell(0, 1, 8'hFF);
    push_cell(0, 2, 8'h41);
    push_cell(1, 0, 8'h42);
    push_cell(1, 1, 8'h41);
    push_cell(1, 2, 8'hFF);
    push_cell(31, 31, 8'h80);
    plan_word = '{8'h00};
    push_word();
    plan_word = '{8'hFF, 8'hFF};
    push_word();
    plan_word = '{8'h41, 8'h42};
    push_word();
    plan_word = '{8'h00, 8'hFF, 8'h41};
    push_word();
    plan_word = '{8'h5A};
    push_word();

    // Empty area: nothing can be found
    set_area(SPAN_W'(0), SPAN_W'(3));
    plan_word = '{8'h41};
    push_word();
    set_area(SPAN_W'(2), SPAN_W'(0));
    plan_word = '{8'h42};
    push_word();

    // Random phases, each under its own area setting
    phase = 0;
    while (n_queued < ITEM_TARGET || n_words < MIN_WORDS) begin
      case (phase)
        0: begin r_sel = SPAN_W'(63); c_sel = SPAN_W'(1); end
        1: begin r_sel = SPAN_W'(1);  c_sel = SPAN_W'(32); end
        2: begin r_sel = SPAN_W'(32); c_sel = SPAN_W'(2); end
        3: begin r_sel = SPAN_W'(2);  c_sel = SPAN_W'(63); end
        default: begin
          sel = $urandom_range(0, 9);
          if (sel == 0) begin
            r_sel = SPAN_W'($urandom_range(0, 1) ? 0 : $urandom_range(1, 6));
            c_sel = (r_sel == 0) ? SPAN_W'($urandom_range(1, 6)) : SPAN_W'(0);
          end else if (sel == 1) begin
            r_sel = SPAN_W'($urandom_range(32, 63));
            c_sel = SPAN_W'($urandom_range(1, 2));
          end else if (sel == 2) begin
            r_sel = SPAN_W'($urandom_range(1, 2));
            c_sel = SPAN_W'($urandom_range(32, 63));
          end else begin
            r_sel = SPAN_W'($urandom_range(1, 6));
            c_sel = SPAN_W'($urandom_range(1, 6));
          end
        end
      endcase
      set_area(r_sel, c_sel);
      fill_area();
      n_body = $urandom_range(4, 9);
      repeat (n_body) begin
        kind = $urandom_range(0, 24);
        if (kind < 14) begin
          plan_path_word();
          push_word();
        end else if (kind < 21) begin
          plan_random_word($urandom_range(1, 6));
          push_word();
        end else if (kind < 23) begin
          push_cell($urandom_range(0, MAX_ROWS - 1), $urandom_range(0, MAX_COLS - 1),
                    CHAR_W'($urandom_range(0, 255)));
        end else if (kind == 23) begin
          plan_random_word(WORD_DEPTH);
          push_word();
        end else begin
          plan_random_word($urandom_range(WORD_DEPTH + 1, WORD_DEPTH + 3));
          push_word();
        end
      end
      if (n_queued >= CALM_FROM) calm = 1'b1;
      phase++;
    end

    // Drain and report
    settle();
    if (n_mismatch == 0 && pending_matches.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

@@ grid_word_search_8dir.f @@
src/gws_pkg.sv
src/gws_ram.sv
src/gws_search.sv
src/grid_word_search_8dir.sv
test/tb_grid_word_search_8dir.sv
